>>> src/sps_pkg.sv
// Shared types and constants for the scratch page slot allocator.
// Request/response structs, command and status codes, register map, bit search.
// No dependencies.
package sps_pkg;

  localparam int unsigned VaW   = 48;  // virtual address width
  localparam int unsigned PaW   = 52;  // physical address width
  localparam int unsigned WordW = 64;  // bitmap word width
  localparam int unsigned BitW  = 6;   // bit index within a word
  localparam int unsigned PageW = 12;  // 4 KiB page offset bits
  localparam int unsigned PteW  = 3;   // 8-byte entry offset bits
  localparam int unsigned CfgDw = 64;  // config data width
  localparam int unsigned CfgAw = 4;   // config address width

  localparam logic [VaW-1:0] VirtBaseReset  = 48'h00_7FC0_0000_00;
  localparam logic [PaW-1:0] TableBaseReset = '0;
  localparam logic [PaW-1:0] EntryFlags     = 52'd3;  // present | writable

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_REASSIGN = 2'd2,
    CMD_NOP      = 2'd3
  } sps_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ALIGN = 2'd3
  } sps_status_e;

  // Register select is paddr bit 3 (registers at byte offsets 0 and 8).
  typedef enum logic {
    REG_VIRT_BASE  = 1'b0,
    REG_TABLE_BASE = 1'b1
  } sps_reg_e;

  typedef struct packed {
    sps_cmd_e          cmd;
    logic [VaW-1:0]    page_addr;
    logic [PaW-1:0]    phys_addr;
  } sps_req_t;

  typedef struct packed {
    sps_status_e       status;
    logic [VaW-1:0]    virt_addr;
    logic              entry_write;
    logic [PaW-1:0]    entry_addr;
    logic [PaW-1:0]    entry_value;
    logic              invalidate;
  } sps_rsp_t;

  // Index of the lowest clear bit; only meaningful when the word has one.
  function automatic logic [BitW-1:0] first_zero(input logic [WordW-1:0] w);
    logic [BitW-1:0] idx;
    idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!w[i]) idx = BitW'(i);
    end
    return idx;
  endfunction

endpackage

>>> src/scratch_page_slot_allocator.sv
// Scratch page slot allocator top level: command sequencer around the bitmap.
// Depends on sps_pkg, sps_map_ram and sps_apb_regs.
//
// Usage: requests arrive on in_req_i (valid/stall), one response per request
// leaves on out_rsp_o (valid/stall). Allocate claims the lowest free slot and
// returns its virtual address plus the entry write and invalidate to issue;
// free clears a slot; reassign rewrites an entry. Config (virt_base,
// table_base) sits on the APB port at byte offsets 0 and 8; the user must
// write it only while the block is idle, which the block does not enforce.
// Each request goes through decode, then for allocate and free a bitmap
// read and update/write back (allocate reads on past each full word), then
// address build for allocate and reassign, then the response hand-off;
// rejected or unused commands go from decode to hand-off. One request is
// worked on at a time; the next can be accepted at the hand-off.
// A first-fit hint (all words below it are full) usually lets allocate hit
// on its first read; a full answer comes from decode or from the last word read.
// Reset: registers go to their defaults and the bitmap is cleared, one word per
// cycle over all TABLE_COUNT*8 words; in_stall_o is high until done.
// A stalled response is held in the output register; the next request can
// still be accepted and worked on, and waits at hand-off until it drains.
module scratch_page_slot_allocator #(
  parameter int unsigned TABLE_COUNT = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sps_pkg::sps_req_t         in_req_i,
  // response channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sps_pkg::sps_rsp_t         out_rsp_o,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sps_pkg::CfgAw-1:0] paddr,
  input  logic [sps_pkg::CfgDw-1:0] pwdata,
  output logic [sps_pkg::CfgDw-1:0] prdata,
  output logic                      pready
);
  import sps_pkg::*;

  localparam int unsigned Words     = TABLE_COUNT * 8;
  localparam int unsigned SlotCount = TABLE_COUNT * 512;
  localparam int unsigned WW        = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned HW        = $clog2(Words + 1);
  localparam int unsigned SW        = WW + BitW;
  localparam int unsigned PnW       = VaW - PageW;  // page number width

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_MOD,
    S_ADDR,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [WW-1:0]   clr_q, clr_d;
  logic [HW-1:0]   hint_q, hint_d;    // words below hint are all full
  logic            out_valid_q, out_valid_d;
  sps_rsp_t        out_q, out_d;
  sps_req_t        req_q, req_d;
  sps_rsp_t        res_q, res_d;
  logic [SW-1:0]   slot_q, slot_d;
  logic [WW-1:0]   word_q, word_d;

  logic [VaW-1:0]   virt_base;
  logic [PaW-1:0]   table_base;

  // bitmap port
  logic             ram_we, ram_re;
  logic [WW-1:0]    ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  // decode helpers
  logic [VaW-1:0]   offset;
  logic [PnW-1:0]   page_num;
  logic             in_range, misaligned;
  logic [BitW-1:0]  free_bit;
  logic [WordW-1:0] bit_mask, set_word;
  logic             push_ok, accept;

  sps_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .virt_base_o  (virt_base),
    .table_base_o (table_base)
  );

  sps_map_ram #(
    .Depth (Words),
    .AddrW (WW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign offset     = req_q.page_addr - virt_base;
  assign page_num   = offset[VaW-1:PageW];
  assign in_range   = page_num < PnW'(SlotCount);
  assign misaligned = |req_q.phys_addr[PageW-1:0];
  assign free_bit   = first_zero(ram_rdata);
  assign bit_mask   = (req_q.cmd == CMD_ALLOC) ? (WordW'(1) << free_bit)
                                               : (WordW'(1) << slot_q[BitW-1:0]);
  assign set_word   = ram_rdata | bit_mask;

  // output register can take a new response this cycle
  assign push_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_DONE) && push_ok));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    hint_d      = hint_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    req_d       = req_q;
    res_d       = res_q;
    slot_d      = slot_q;
    word_d      = word_q;
    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = set_word;
    ram_re      = 1'b0;

    if (accept) req_d = in_req_i;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + WW'(1);
        if (clr_q == WW'(Words - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_DEC;
      end
      S_DEC: begin
        res_d   = '0;
        slot_d  = page_num[SW-1:0];
        state_d = S_DONE;
        case (req_q.cmd)
          CMD_ALLOC: begin
            if (misaligned) begin
              res_d.status = ST_ALIGN;
            end else if (hint_q == HW'(Words)) begin
              res_d.status = ST_FULL;
            end else begin
              word_d  = hint_q[WW-1:0];
              ram_re  = 1'b1;
              state_d = S_MOD;
            end
          end
          CMD_FREE: begin
            if (!in_range) begin
              res_d.status = ST_RANGE;
            end else begin
              word_d  = page_num[SW-1:BitW];
              ram_re  = 1'b1;
              state_d = S_MOD;
            end
          end
          CMD_REASSIGN: begin
            if (!in_range) begin
              res_d.status = ST_RANGE;
            end else if (misaligned) begin
              res_d.status = ST_ALIGN;
            end else begin
              state_d = S_ADDR;
            end
          end
          default: res_d = '0;
        endcase
      end
      S_MOD: begin
        // read data for word_q is valid; the next request reads only after passing
        // S_DONE and S_DEC, after this write, so no bypass is needed
        if (req_q.cmd == CMD_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~bit_mask;
          if (HW'(word_q) < hint_q) hint_d = HW'(word_q);
          res_d     = '0;
          state_d   = S_DONE;
        end else if (&ram_rdata) begin
          // word full: move the hint past it and try the next one
          hint_d = HW'(word_q) + HW'(1);
          if (HW'(word_q) + HW'(1) == HW'(Words)) begin
            res_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            word_d = word_q + WW'(1);
            ram_re = 1'b1;
          end
        end else begin
          ram_we  = 1'b1;
          slot_d  = {word_q, free_bit};
          hint_d  = (&set_word) ? HW'(word_q) + HW'(1) : HW'(word_q);
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        res_d.status      = ST_OK;
        res_d.virt_addr   = virt_base + (VaW'(slot_q) << PageW);
        res_d.entry_write = 1'b1;
        res_d.entry_addr  = table_base + (PaW'(slot_q) << PteW);
        res_d.entry_value = req_q.phys_addr | EntryFlags;
        res_d.invalidate  = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (push_ok) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = accept ? S_DEC : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // read address follows the word picked above
    ram_raddr = word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    req_q  <= req_d;
    res_q  <= res_d;
    slot_q <= slot_d;
    word_q <= word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

>>> src/sps_map_ram.sv
// Slot bitmap storage: one write port, one read port, registered read data.
// Depends on sps_pkg for the word width.
module sps_map_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [sps_pkg::WordW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [sps_pkg::WordW-1:0] rdata_o
);
  import sps_pkg::*;

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sps_apb_regs.sv
// APB register file: virtual base of slot zero and base of the entry tables.
// Depends on sps_pkg for the register map and reset values.
module sps_apb_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sps_pkg::CfgAw-1:0] paddr,
  input  logic [sps_pkg::CfgDw-1:0] pwdata,
  output logic [sps_pkg::CfgDw-1:0] prdata,
  output logic                      pready,
  output logic [sps_pkg::VaW-1:0]   virt_base_o,
  output logic [sps_pkg::PaW-1:0]   table_base_o
);
  import sps_pkg::*;

  logic [VaW-1:0] virt_base_q, virt_base_d;
  logic [PaW-1:0] table_base_q, table_base_d;
  sps_reg_e       sel;
  logic           wr_en;

  assign sel    = sps_reg_e'(paddr[3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    virt_base_d  = virt_base_q;
    table_base_d = table_base_q;
    prdata       = '0;
    unique case (sel)
      REG_VIRT_BASE: begin
        prdata = CfgDw'(virt_base_q);
        if (wr_en) virt_base_d = pwdata[VaW-1:0];
      end
      REG_TABLE_BASE: begin
        prdata = CfgDw'(table_base_q);
        if (wr_en) table_base_d = pwdata[PaW-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      virt_base_q  <= VirtBaseReset;
      table_base_q <= TableBaseReset;
    end else begin
      virt_base_q  <= virt_base_d;
      table_base_q <= table_base_d;
    end
  end

  assign virt_base_o  = virt_base_q;
  assign table_base_o = table_base_q;

endmodule

>>> bench/testbench.sv
// Self-checking bench for scratch_page_slot_allocator: directed table, then random phases.
// Depends on sps_pkg and the RTL under src/. Needs no files or arguments.
`timescale 1ns / 1ps

module testbench;
  import sps_pkg::*;

  localparam int unsigned TABLE_COUNT = 1;
  localparam int unsigned MAP_WORDS   = TABLE_COUNT * 8;
  localparam int unsigned SLOT_COUNT  = TABLE_COUNT * 512;
  localparam int unsigned LIMIT       = 400_000;  // cycles, far above the slowest run
  localparam int unsigned PHASE_LEN   = 270;      // random requests per register setting
  localparam int unsigned SETTLE      = 20;       // cycles after the last response

  // one row of the directed table; rsp is only used when known is set
  typedef struct {
    sps_req_t req;
    bit       known;
    sps_rsp_t rsp;
  } plan_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  sps_req_t            in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sps_rsp_t            out_rsp_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAw-1:0]    paddr       = '0;
  logic [CfgDw-1:0]    pwdata      = '0;
  logic [CfgDw-1:0]    prdata;
  logic                pready;

  // shadow of the block: registers and slot bitmap
  logic [VaW-1:0]      virt_base  = VirtBaseReset;
  logic [PaW-1:0]      table_base = TableBaseReset;
  logic [WordW-1:0]    slot_map [MAP_WORDS];

  sps_rsp_t            pending_rsp [$];  // responses owed by the block, oldest first
  sps_rsp_t            head;
  int unsigned         errors     = 0;
  int unsigned         cycles     = 0;
  int unsigned         rsp_count  = 0;
  int unsigned         cmd_count [4];
  int unsigned         status_count [4];
  bit                  calm       = 1'b0;  // no idling on either side while set

  always #1 clk_i = ~clk_i;

  scratch_page_slot_allocator #(
    .TABLE_COUNT(TABLE_COUNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("response %0d %s: got %h, expected %h", rsp_count, name, got, want));
    end
  endtask

  function automatic logic [VaW-1:0] rand48();
    return VaW'({$urandom, $urandom});
  endfunction

  function automatic logic [PaW-1:0] rand52();
    return PaW'({$urandom, $urandom});
  endfunction

  // Bitmap allocator behavior: one response per request, state updated in place.
  function automatic sps_rsp_t slot_outcome(input sps_req_t r);
    sps_rsp_t        rsp;
    logic [VaW-1:0]  offset;
    logic [35:0]     page;
    int unsigned     slot;
    bit              hit;
    rsp    = '0;
    offset = r.page_addr - virt_base;  // wraps mod 2^48
    page   = offset[VaW-1:PageW];
    slot   = 0;
    hit    = 1'b0;
    case (r.cmd)
      CMD_ALLOC: begin
        if (r.phys_addr[PageW-1:0] != '0) begin
          rsp.status = ST_ALIGN;
        end else begin
          // lowest clear bit, word by word
          for (int w = 0; w < MAP_WORDS && !hit; w++) begin
            for (int b = 0; b < WordW && !hit; b++) begin
              if (!slot_map[w][b]) begin
                slot = w * WordW + b;
                hit  = 1'b1;
              end
            end
          end
          if (!hit) begin
            rsp.status = ST_FULL;
          end else begin
            slot_map[slot / WordW][slot % WordW] = 1'b1;
            rsp.status      = ST_OK;
            rsp.virt_addr   = virt_base + (VaW'(slot) << PageW);
            rsp.entry_write = 1'b1;
            rsp.entry_addr  = table_base + (PaW'(slot) << PteW);
            rsp.entry_value = r.phys_addr | EntryFlags;
            rsp.invalidate  = 1'b1;
          end
        end
      end
      CMD_FREE: begin
        if (page >= SLOT_COUNT) begin
          rsp.status = ST_RANGE;
        end else begin
          slot = int'(page);
          slot_map[slot / WordW][slot % WordW] = 1'b0;
        end
      end
      CMD_REASSIGN: begin
        // range is checked ahead of frame alignment
        if (page >= SLOT_COUNT) begin
          rsp.status = ST_RANGE;
        end else if (r.phys_addr[PageW-1:0] != '0) begin
          rsp.status = ST_ALIGN;
        end else begin
          slot = int'(page);
          rsp.status      = ST_OK;
          rsp.virt_addr   = virt_base + (VaW'(slot) << PageW);
          rsp.entry_write = 1'b1;
          rsp.entry_addr  = table_base + (PaW'(slot) << PteW);
          rsp.entry_value = r.phys_addr | EntryFlags;
          rsp.invalidate  = 1'b1;
        end
      end
      default: ;  // unused command: all-zero response
    endcase
    return rsp;
  endfunction

  // Directed row; the flag bits of a typed response follow from a nonzero entry value.
  function automatic plan_row_t row(input sps_cmd_e cmd, input logic [VaW-1:0] page,
                                    input logic [PaW-1:0] phys, input bit known,
                                    input sps_status_e st, input logic [VaW-1:0] va,
                                    input logic [PaW-1:0] ea, input logic [PaW-1:0] ev);
    plan_row_t p;
    p.req.cmd             = cmd;
    p.req.page_addr       = page;
    p.req.phys_addr       = phys;
    p.known               = known;
    p.rsp.status          = st;
    p.rsp.virt_addr       = va;
    p.rsp.entry_write     = (ev != '0);
    p.rsp.entry_addr      = ea;
    p.rsp.entry_value     = ev;
    p.rsp.invalidate      = (ev != '0);
    return p;
  endfunction

  // Random request; page addresses mostly land on real slots of the current base.
  function automatic sps_req_t random_request(input int unsigned alloc_pct);
    sps_req_t    r;
    int unsigned roll;
    int unsigned where;
    roll  = $urandom_range(99);
    where = $urandom_range(99);
    if (roll < alloc_pct) r.cmd = CMD_ALLOC;
    else if (roll >= 97) r.cmd = CMD_NOP;
    else if (roll % 2)   r.cmd = CMD_FREE;
    else                 r.cmd = CMD_REASSIGN;
    if (where < 85) begin
      r.page_addr = virt_base + (VaW'($urandom_range(SLOT_COUNT - 1)) << PageW)
                    + VaW'($urandom_range(4095));
    end else if (where < 93) begin
      // just past the last slot
      r.page_addr = virt_base + (VaW'($urandom_range(SLOT_COUNT, SLOT_COUNT + 90)) << PageW)
                    + VaW'($urandom_range(4095));
    end else if (where < 96) begin
      r.page_addr = virt_base - VaW'($urandom_range(1, 4096));
    end else begin
      r.page_addr = rand48();
    end
    r.phys_addr = ($urandom_range(99) < 90) ? (rand52() & ~PaW'(12'hFFF)) : rand52();
    return r;
  endfunction

  // APB write, then read back and compare.
  task automatic set_reg(input sps_reg_e idx, input logic [CfgDw-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_VIRT_BASE) virt_base = value[VaW-1:0];
    else                      table_base = value[PaW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== value) begin
      report($sformatf("register %s reads %h, expected %h", idx.name(), prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold a request until the block takes it, then record what it owes.
  task automatic send(input sps_req_t r, input bit known, input sps_rsp_t typed);
    sps_rsp_t predicted;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = slot_outcome(r);
    pending_rsp.push_back(known ? typed : predicted);
    cmd_count[r.cmd]++;
  endtask

  // Random sender gap; with drain set, also wait until every response is back.
  task automatic pause_after(input bit drain);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < 11) ? $urandom_range(1, 5) : 0;
    if (gap != 0 || drain) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain && pending_rsp.size() != 0) @(posedge clk_i);
    end
  endtask

  // Response side: compare each accepted response, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected response %h", out_rsp_o));
      end else begin
        head = pending_rsp.pop_front();
        check_field("status", out_rsp_o.status, head.status);
        check_field("virt_addr", out_rsp_o.virt_addr, head.virt_addr);
        check_field("entry_write", out_rsp_o.entry_write, head.entry_write);
        check_field("entry_addr", out_rsp_o.entry_addr, head.entry_addr);
        check_field("entry_value", out_rsp_o.entry_value, head.entry_value);
        check_field("invalidate", out_rsp_o.invalidate, head.invalidate);
      end
      status_count[out_rsp_o.status]++;
      rsp_count++;
    end
    out_stall_i <= !calm && ($urandom_range(99) < 11);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               pending_rsp.size());
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus: reset, directed table at reset settings, then random phases.
  initial begin
    plan_row_t       plan [$];
    logic [VaW-1:0]  vb;
    logic [VaW-1:0]  phase_vb [5];
    logic [PaW-1:0]  phase_tb [5];
    int unsigned     phase_pct [5];
    sps_req_t        req;

    vb = VirtBaseReset;
    foreach (slot_map[w]) slot_map[w] = '0;
    foreach (cmd_count[k]) cmd_count[k] = 0;
    foreach (status_count[k]) status_count[k] = 0;

    // Directed table. Typed responses assume the reset base and the map state so far.
    // Two good allocations, then frame alignment errors on allocate and range errors on free
    plan.push_back(row(CMD_ALLOC, '0, '0, 1, ST_OK, vb, '0, 52'h3));
    plan.push_back(row(CMD_ALLOC, '1, 52'hF_FFFF_FFFF_F000, 1, ST_OK,
                       vb + 48'h1000, 52'h8, 52'hF_FFFF_FFFF_F003));
    plan.push_back(row(CMD_ALLOC, '0, 52'h1, 1, ST_ALIGN, '0, '0, '0));
    plan.push_back(row(CMD_ALLOC, '0, '1, 1, ST_ALIGN, '0, '0, '0));
    plan.push_back(row(CMD_ALLOC, '0, 52'h800, 1, ST_ALIGN, '0, '0, '0));
    plan.push_back(row(CMD_FREE, '0, '0, 1, ST_RANGE, '0, '0, '0));
    plan.push_back(row(CMD_FREE, '1, '1, 1, ST_RANGE, '0, '0, '0));
    plan.push_back(row(CMD_FREE, vb + 48'h20_0000, '0, 1, ST_RANGE, '0, '0, '0));
    plan.push_back(row(CMD_FREE, vb - 48'h1, '0, 1, ST_RANGE, '0, '0, '0));
    // free ignores the page offset; a second free of the same slot is harmless
    plan.push_back(row(CMD_FREE, vb + 48'hFFF, '0, 1, ST_OK, '0, '0, '0));
    plan.push_back(row(CMD_FREE, vb, '0, 1, ST_OK, '0, '0, '0));
    // freed slot zero is reused first, then the next hole
    plan.push_back(row(CMD_ALLOC, '0, 52'hABCD000, 1, ST_OK, vb, '0, 52'hABCD003));
    plan.push_back(row(CMD_ALLOC, '0, 52'h5000, 1, ST_OK, vb + 48'h2000, 52'h10, 52'h5003));
    // reassign: taken slot, free last slot, range before alignment
    plan.push_back(row(CMD_REASSIGN, vb + 48'h1FFF, 52'h7000, 1, ST_OK,
                       vb + 48'h1000, 52'h8, 52'h7003));
    plan.push_back(row(CMD_REASSIGN, vb + 48'h1F_F000, 52'hF_FFFF_FFFF_F000, 1, ST_OK,
                       vb + 48'h1F_F000, 52'hFF8, 52'hF_FFFF_FFFF_F003));
    plan.push_back(row(CMD_REASSIGN, '0, 52'h1, 1, ST_RANGE, '0, '0, '0));
    plan.push_back(row(CMD_REASSIGN, vb + 48'h3000, 52'hFFF, 1, ST_ALIGN, '0, '0, '0));
    plan.push_back(row(CMD_REASSIGN, vb + 48'h20_0000, '0, 1, ST_RANGE, '0, '0, '0));
    plan.push_back(row(CMD_FREE, vb + 48'h1F_FFFF, '0, 1, ST_OK, '0, '0, '0));
    // unused command with every payload bit set and clear
    plan.push_back(row(CMD_NOP, '1, '1, 1, ST_OK, '0, '0, '0));
    plan.push_back(row(CMD_NOP, '0, '0, 1, ST_OK, '0, '0, '0));
    // left to the shadow model
    plan.push_back(row(CMD_ALLOC, '1, 52'h9000, 0, ST_OK, '0, '0, '0));
    plan.push_back(row(CMD_FREE, vb + 48'h2000, '0, 0, ST_OK, '0, '0, '0));
    plan.push_back(row(CMD_ALLOC, '0, 52'h1234_5678_9000, 0, ST_OK, '0, '0, '0));

    // register settings per phase: bases at zero, wrapping, all ones, and random
    phase_vb[0] = '0;                   phase_tb[0] = '0;                  phase_pct[0] = 80;
    phase_vb[1] = 48'hFFFF_FFFF_F000;   phase_tb[1] = 52'hF_FFFF_FFFF_FFF8; phase_pct[1] = 85;
    phase_vb[2] = rand48();             phase_tb[2] = rand52();            phase_pct[2] = 80;
    phase_vb[3] = '1;                   phase_tb[3] = '1;                  phase_pct[3] = 30;
    phase_vb[4] = rand48();             phase_tb[4] = '0;                  phase_pct[4] = 50;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send(plan[i].req, plan[i].known, plan[i].rsp);
      pause_after(i == plan.size() - 1);
    end

    // Allocate-heavy phases fill the map so later ones see full answers, then drain it.
    for (int p = 0; p < 5; p++) begin
      set_reg(REG_VIRT_BASE, CfgDw'(phase_vb[p]));
      set_reg(REG_TABLE_BASE, CfgDw'(phase_tb[p]));
      @(posedge clk_i);
      for (int i = 0; i < PHASE_LEN; i++) begin
        calm = (p == 1 && i < 200);  // long stretch with no idling anywhere
        req  = random_request(phase_pct[p]);
        send(req, 0, '0);
        // mid-phase hold-off until the block has answered everything
        pause_after(i == PHASE_LEN - 1 || (p == 2 && i == 120));
      end
      calm = 1'b0;
    end

    repeat (SETTLE) @(posedge clk_i);
    if (pending_rsp.size() != 0) report($sformatf("%0d responses never came", pending_rsp.size()));
    $display("covered %0d requests (alloc %0d, free %0d, reassign %0d, unused %0d) over 6 settings",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
             cmd_count[CMD_ALLOC], cmd_count[CMD_FREE], cmd_count[CMD_REASSIGN],
             cmd_count[CMD_NOP]);
    $display("responses %0d: ok %0d, full %0d, range %0d, misaligned %0d; %0d mismatches",
             rsp_count, status_count[ST_OK], status_count[ST_FULL], status_count[ST_RANGE],
             status_count[ST_ALIGN], errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/sps_pkg.sv
src/sps_map_ram.sv
src/sps_apb_regs.sv
src/scratch_page_slot_allocator.sv
bench/testbench.sv
